// ===== hw/rtl/tkec_pkg.sv =====
// Package for the touch key event classifier.
// Holds the event codes, register indexes, field widths and the result word type.
// No dependencies.
`timescale 1ns / 1ps

package tkec_pkg;

    localparam int unsigned THRESH_W   = 16;
    localparam int unsigned FILTER_W   = 12;
    localparam int unsigned LONG_SEC_W = 12;
    localparam int unsigned LONG_MS_W  = 22;   // 4095 * 1000 fits in 22 bits
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned TICK_W     = 32;
    localparam int unsigned HELD_W     = 32;
    localparam int unsigned PHASE_W    = 3;
    localparam int unsigned EVENT_W    = 2;

    localparam logic [9:0]         MS_PER_SEC    = 10'd1000;
    localparam logic [PHASE_W-1:0] PHASE_LAST    = 3'd4;   // five polls per repeat
    localparam logic [FILTER_W-1:0] FILTER_RESET = 12'd10;

    // result queue
    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QAW    = 2;

    typedef enum logic [EVENT_W-1:0] {
        EV_PUSH    = 2'd0,
        EV_RELEASE = 2'd1,
        EV_TAP     = 2'd2,
        EV_LONG    = 2'd3
    } event_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_THRESHOLD = 2'd0,
        REG_FILTER_MS = 2'd1,
        REG_LONG_SEC  = 2'd2,
        REG_SERIAL    = 2'd3
    } reg_idx_t;

    typedef struct packed {
        event_t event_res;
        logic   last;
    } result_t;

endpackage

// ===== hw/rtl/tkec_if.sv =====
// Channel interfaces of the touch key event classifier: input word and result word.
// Depends on tkec_pkg.
`timescale 1ns / 1ps

interface tkec_in_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [15:0] sample;

    modport source (output valid, output mode, output sample, input ready);
    modport sink   (input valid, input mode, input sample, output ready);
endinterface

interface tkec_out_if;
    logic                          valid;
    logic                          ready;
    logic [tkec_pkg::EVENT_W-1:0]  event_res;
    logic                          last;

    modport source (output valid, output event_res, output last, input ready);
    modport sink   (input valid, input event_res, input last, output ready);
endinterface

// ===== hw/rtl/touch_key_event_classifier.sv =====
// Results: the events of an accepted input word are registered into the result queue
// and offered from its head; a second result of the same word sits in the entry behind the first.
// Throughput: one input word per cycle while the 4-entry result queue has at least two free slots.
// Reset: rst_n asynchronous active low; clears all pad state and the queue, and loads
// register defaults (threshold 0, filter_ms 10, long press off, serial off).
// Depends on tkec_pkg and tkec_if.
`timescale 1ns / 1ps

module touch_key_event_classifier (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [tkec_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tkec_pkg::CFG_DATA_W-1:0]    cfg_data,
    tkec_in_if.sink                            pad,
    tkec_out_if.source                         evt
);

    // ------------------------------------------------------------------
    // Configuration registers. Long press time is kept in milliseconds,
    // multiplied out at write time so the poll path only compares.
    // ------------------------------------------------------------------
    logic [tkec_pkg::THRESH_W-1:0]  threshold_reg;
    logic [tkec_pkg::FILTER_W-1:0]  filter_reg;
    logic [tkec_pkg::LONG_MS_W-1:0] long_ms_reg;
    logic                           serial_reg;

    logic [tkec_pkg::LONG_MS_W-1:0] long_ms_wr;
    assign long_ms_wr = tkec_pkg::LONG_MS_W'(cfg_data[tkec_pkg::LONG_SEC_W-1:0])
                        * tkec_pkg::LONG_MS_W'(tkec_pkg::MS_PER_SEC);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= '0;
            filter_reg    <= tkec_pkg::FILTER_RESET;
            long_ms_reg   <= '0;
            serial_reg    <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (tkec_pkg::reg_idx_t'(cfg_index))
                tkec_pkg::REG_THRESHOLD: threshold_reg <= cfg_data;
                tkec_pkg::REG_FILTER_MS: filter_reg    <= cfg_data[tkec_pkg::FILTER_W-1:0];
                tkec_pkg::REG_LONG_SEC:  long_ms_reg   <= long_ms_wr;
                tkec_pkg::REG_SERIAL:    serial_reg    <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pad state
    // ------------------------------------------------------------------
    logic [tkec_pkg::TICK_W-1:0]   tick_reg,     tick_next;
    logic [tkec_pkg::TICK_W-1:0]   last_int_reg, last_int_next;
    logic [tkec_pkg::FILTER_W-1:0] countdown_reg, countdown_next;
    logic                          armed_reg,    armed_next;
    logic [tkec_pkg::HELD_W-1:0]   held_reg,     held_next;
    logic [tkec_pkg::PHASE_W-1:0]  phase_reg,    phase_next;
    logic                          long_rep_reg, long_rep_next;

    // result queue
    tkec_pkg::result_t             q_reg [tkec_pkg::QDEPTH];
    logic [tkec_pkg::QAW-1:0]      head_reg, head_next;
    logic [tkec_pkg::QAW-1:0]      tail_reg, tail_next;
    logic [tkec_pkg::QAW:0]        count_reg, count_next;

    logic accept, pop;
    assign pad.ready = (count_reg <= 3'(tkec_pkg::QDEPTH - 2));
    assign accept    = pad.valid && pad.ready;
    assign pop       = evt.valid && evt.ready;

    // ------------------------------------------------------------------
    // Classifier step: up to two events per accepted word
    // ------------------------------------------------------------------
    logic [tkec_pkg::TICK_W-1:0]  int_gap;
    logic [tkec_pkg::HELD_W:0]    held_sum;
    logic [tkec_pkg::HELD_W-1:0]  held_sat;
    logic [tkec_pkg::PHASE_W-1:0] phase_inc;
    logic                         touched;
    logic                         long_fire;
    logic [1:0]                   n_res;
    tkec_pkg::event_t             ev0, ev1;

    assign int_gap   = tick_reg - last_int_reg;
    assign held_sum  = {1'b0, held_reg} + (tkec_pkg::HELD_W + 1)'(filter_reg);
    assign held_sat  = held_sum[tkec_pkg::HELD_W] ? '1 : held_sum[tkec_pkg::HELD_W-1:0];
    // out-of-range phases behave like the last phase
    assign phase_inc = (phase_reg >= tkec_pkg::PHASE_LAST) ? '0 : phase_reg + 3'd1;
    assign touched   = pad.sample < threshold_reg;
    assign long_fire = !long_rep_reg && (long_ms_reg != '0)
                       && (held_sat >= tkec_pkg::HELD_W'(long_ms_reg));

    always_comb
    begin
        tick_next      = tick_reg;
        last_int_next  = last_int_reg;
        countdown_next = countdown_reg;
        armed_next     = armed_reg;
        held_next      = held_reg;
        phase_next     = phase_reg;
        long_rep_next  = long_rep_reg;
        n_res          = 2'd0;
        ev0            = tkec_pkg::EV_PUSH;
        ev1            = tkec_pkg::EV_TAP;

        if (accept)
        begin
            if (pad.mode)
            begin
                // touch interrupt: debounce against the previous one
                last_int_next = tick_reg;
                if (int_gap > tkec_pkg::TICK_W'(filter_reg))
                begin
                    n_res          = 2'd1;
                    ev0            = tkec_pkg::EV_PUSH;
                    countdown_next = filter_reg;
                    armed_next     = 1'b1;
                end
            end
            else
            begin
                tick_next = tick_reg + 32'd1;
                if (armed_reg)
                begin
                    if (countdown_reg <= 12'd1)
                    begin
                        // poll timer expired
                        countdown_next = '0;
                        armed_next     = 1'b0;
                        if (touched)
                        begin
                            held_next      = held_sat;
                            phase_next     = phase_inc;
                            countdown_next = filter_reg;
                            armed_next     = 1'b1;
                            if (long_fire)
                            begin
                                n_res         = 2'd1;
                                ev0           = tkec_pkg::EV_LONG;
                                long_rep_next = 1'b1;
                                phase_next    = '0;
                            end
                            else if (serial_reg && phase_inc == '0)
                            begin
                                if (long_ms_reg == '0)
                                begin
                                    n_res = 2'd1;
                                    ev0   = tkec_pkg::EV_TAP;
                                end
                                else if (long_rep_reg)
                                begin
                                    n_res = 2'd1;
                                    ev0   = tkec_pkg::EV_LONG;
                                end
                            end
                        end
                        else
                        begin
                            // release, then tap unless a long press was seen
                            ev0           = tkec_pkg::EV_RELEASE;
                            ev1           = tkec_pkg::EV_TAP;
                            n_res         = long_rep_reg ? 2'd1 : 2'd2;
                            held_next     = '0;
                            phase_next    = '0;
                            long_rep_next = 1'b0;
                        end
                    end
                    else
                    begin
                        countdown_next = countdown_reg - 12'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg      <= '0;
            last_int_reg  <= '0;
            countdown_reg <= '0;
            armed_reg     <= 1'b0;
            held_reg      <= '0;
            phase_reg     <= '0;
            long_rep_reg  <= 1'b0;
        end
        else
        begin
            tick_reg      <= tick_next;
            last_int_reg  <= last_int_next;
            countdown_reg <= countdown_next;
            armed_reg     <= armed_next;
            held_reg      <= held_next;
            phase_reg     <= phase_next;
            long_rep_reg  <= long_rep_next;
        end
    end

    // ------------------------------------------------------------------
    // Result queue: up to two writes per cycle at tail, one read at head
    // ------------------------------------------------------------------
    assign tail_next  = tail_reg + tkec_pkg::QAW'(n_res);
    assign head_next  = head_reg + tkec_pkg::QAW'(pop);
    assign count_next = count_reg + (tkec_pkg::QAW + 1)'(n_res)
                        - (tkec_pkg::QAW + 1)'(pop);

    always_ff @(posedge clk)
    begin
        if (n_res != 2'd0)
        begin
            q_reg[tail_reg].event_res <= ev0;
            q_reg[tail_reg].last      <= (n_res == 2'd1);
        end
        if (n_res == 2'd2)
        begin
            q_reg[tail_reg + 2'd1].event_res <= ev1;
            q_reg[tail_reg + 2'd1].last      <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    assign evt.valid     = (count_reg != '0);
    assign evt.event_res = q_reg[head_reg].event_res;
    assign evt.last      = q_reg[head_reg].last;

endmodule

// ===== hw/rtl/tkec_checker.sv =====
// Port-level checker for the touch key event classifier, bound to the top level.
// Depends on tkec_pkg and touch_key_event_classifier.
`timescale 1ns / 1ps

module tkec_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [tkec_pkg::EVENT_W-1:0] out_event,
    input logic                         out_last
);

    // a pending result word stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result word dropped while stalled");

    // no result appears without a prior input or pending word
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(in_valid && in_ready) && !$past(out_valid) |-> !out_valid)
        else $error("result word without cause");

    // only a release can be followed by another word of the same input
    a_nonlast_release: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_last |-> out_event == tkec_pkg::EV_RELEASE)
        else $error("non-final word is not a release");

    // a release that is not final is followed at once by its tap
    a_release_tap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_last
        |=> out_valid && out_last && out_event == tkec_pkg::EV_TAP)
        else $error("release not followed by tap");

endmodule

bind touch_key_event_classifier tkec_checker u_tkec_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (pad.valid),
    .in_ready  (pad.ready),
    .out_valid (evt.valid),
    .out_ready (evt.ready),
    .out_event (evt.event_res),
    .out_last  (evt.last)
);

// ===== verif/touch_key_event_classifier_tb.sv =====
// Self-checking testbench for touch_key_event_classifier: directed and random
// tick/interrupt traffic checked against an in-bench event predictor.
// Depends on tkec_pkg, tkec_if and the classifier RTL.
`timescale 1ns / 1ps

module touch_key_event_classifier_tb;

    // input word kinds (mode field)
    localparam logic MODE_TICK  = 1'b0;
    localparam logic MODE_TOUCH = 1'b1;

    localparam logic [31:0] MSEC_PER_SEC = 32'd1000;
    localparam logic [2:0]  REPEAT_LAST  = 3'd4;     // serial repeat every fifth poll
    localparam int unsigned CYCLE_LIMIT  = 200000;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [tkec_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [tkec_pkg::CFG_DATA_W-1:0] cfg_data;

    tkec_in_if  pad_if ();
    tkec_out_if evt_if ();

    touch_key_event_classifier u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pad       (pad_if),
        .evt       (evt_if)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor state: register shadows and pad bookkeeping.
    // ------------------------------------------------------------------
    logic [15:0] cfg_threshold;
    logic [11:0] cfg_filter;
    logic [11:0] cfg_long_sec;
    logic        cfg_serial;

    logic [31:0] tick_ctr;
    logic [31:0] touch_stamp;    // tick count at the last interrupt
    logic [11:0] poll_left;
    logic        poll_on;
    logic [31:0] held_time;      // ms held in the current press
    logic [2:0]  rep_phase;
    logic        long_seen;

    tkec_pkg::result_t expected_events[$];

    int          err_count   = 0;
    int          words_sent  = 0;
    int          stall_left  = 0;
    int unsigned cycle_count = 0;
    bit          idling_on;

    // Work out the events one accepted input word causes and queue them.
    task automatic classify_word(input logic m, input logic [15:0] s);
        tkec_pkg::event_t  evs[$];
        logic [31:0]       touch_gap;
        logic [31:0]       sum;
        logic              was_long;
        logic              fired;
        tkec_pkg::result_t r;
        if (m == MODE_TOUCH)
        begin
            // debounce: only a push if far enough from the previous interrupt
            touch_gap = tick_ctr - touch_stamp;
            touch_stamp = tick_ctr;
            if (touch_gap > 32'(cfg_filter))
            begin
                evs.push_back(tkec_pkg::EV_PUSH);
                poll_left = cfg_filter;
                poll_on   = 1'b1;
            end
        end
        else
        begin
            tick_ctr = tick_ctr + 32'd1;
            if (poll_on && poll_left > 12'd1)
                poll_left = poll_left - 12'd1;
            else if (poll_on)
            begin
                // timer expired: poll the reading
                poll_left = '0;
                poll_on   = 1'b0;
                if (s < cfg_threshold)
                begin
                    was_long  = long_seen;
                    fired     = 1'b0;
                    sum       = held_time + 32'(cfg_filter);
                    held_time = (sum < held_time) ? '1 : sum;
                    rep_phase = (rep_phase >= REPEAT_LAST) ? 3'd0 : rep_phase + 3'd1;
                    if (!was_long && cfg_long_sec != '0 &&
                        held_time >= 32'(cfg_long_sec) * MSEC_PER_SEC)
                    begin
                        evs.push_back(tkec_pkg::EV_LONG);
                        long_seen = 1'b1;
                        rep_phase = 3'd0;
                        fired     = 1'b1;
                    end
                    if (!fired && cfg_serial && rep_phase == 3'd0)
                    begin
                        if (cfg_long_sec == '0)
                            evs.push_back(tkec_pkg::EV_TAP);
                        else if (was_long)
                            evs.push_back(tkec_pkg::EV_LONG);
                    end
                    poll_left = cfg_filter;
                    poll_on   = 1'b1;
                end
                else
                begin
                    evs.push_back(tkec_pkg::EV_RELEASE);
                    if (!long_seen)
                        evs.push_back(tkec_pkg::EV_TAP);
                    held_time = '0;
                    rep_phase = 3'd0;
                    long_seen = 1'b0;
                end
            end
        end
        foreach (evs[i])
        begin
            r.event_res = evs[i];
            r.last      = (i == evs.size() - 1);
            expected_events.push_back(r);
        end
    endtask

    // ------------------------------------------------------------------
    // Input side: one word per call, optional idle burst before it.
    // valid stays high into the next call so words can go back to back.
    // ------------------------------------------------------------------
    task automatic send_word(input logic m, input logic [15:0] s);
        int gap;
        if (idling_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 5);
            pad_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pad_if.valid  <= 1'b1;
        pad_if.mode   <= m;
        pad_if.sample <= s;
        @(posedge clk);
        while (!pad_if.ready) @(posedge clk);
        classify_word(m, s);
        words_sent++;
    endtask

    // Stop sending, wait for every queued event, then wait out any words that
    // produce nothing but may still be in flight.
    task automatic drain_events();
        pad_if.valid <= 1'b0;
        while (expected_events.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input tkec_pkg::reg_idx_t idx, input logic [15:0] d);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
    endtask

    // Writes all four registers while the block is quiet.
    task automatic load_config(input logic [15:0] t, input logic [11:0] f,
                               input logic [11:0] l, input logic se);
        drain_events();
        write_reg(tkec_pkg::REG_THRESHOLD, t);
        write_reg(tkec_pkg::REG_FILTER_MS, {4'd0, f});
        write_reg(tkec_pkg::REG_LONG_SEC, {4'd0, l});
        write_reg(tkec_pkg::REG_SERIAL, {15'd0, se});
        cfg_we        <= 1'b0;
        cfg_threshold = t;
        cfg_filter    = f;
        cfg_long_sec  = l;
        cfg_serial    = se;
    endtask

    // Readings that count as touched / untouched under the current threshold.
    // With threshold 0 nothing is touched, so any value goes.
    function automatic logic [15:0] held_sample();
        if (cfg_threshold == '0)
            return 16'($urandom);
        return 16'($urandom_range(0, cfg_threshold - 1));
    endfunction

    function automatic logic [15:0] free_sample();
        return 16'($urandom_range(cfg_threshold, 16'hFFFF));
    endfunction

    // One press: quiet ticks, interrupt, held polls with the odd stray
    // interrupt, then untouched ticks until the release shows up.
    // A short quiet gap can make the interrupt a bounce, and the press is then lost.
    task automatic press_cycle(input int max_polls);
        int gap;
        int hold;
        if ($urandom_range(0, 3) == 0)
            gap = $urandom_range(0, cfg_filter);
        else
            gap = cfg_filter + $urandom_range(1, 3);
        repeat (gap) send_word(MODE_TICK, 16'($urandom));
        send_word(MODE_TOUCH, 16'($urandom));
        hold = $urandom_range(0, max_polls) * ((cfg_filter == '0) ? 1 : cfg_filter);
        repeat (hold)
        begin
            if ($urandom_range(0, 49) == 0)
                send_word(MODE_TOUCH, 16'($urandom));
            else
                send_word(MODE_TICK, held_sample());
        end
        while (poll_on)
            send_word(MODE_TICK, ($urandom_range(0, 7) == 0) ? held_sample() : free_sample());
    endtask

    // Mostly well-formed presses, one in ten a random noise word.
    task automatic run_press_traffic(input int n_words, input int max_polls);
        int start;
        start = words_sent;
        while (words_sent - start < n_words)
        begin
            if ($urandom_range(0, 9) == 0)
                send_word(logic'($urandom_range(0, 1)), 16'($urandom));
            else
                press_cycle(max_polls);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Register defaults: filter 10, threshold 0 so every poll releases.
    task automatic test_reset_defaults();
        send_word(MODE_TOUCH, 16'h0000);     // distance 0: bounce
        for (int i = 0; i < 11; i++)
            send_word(MODE_TICK, (i % 2) ? 16'h0000 : 16'hFFFF);
        send_word(MODE_TOUCH, 16'hFFFF);     // distance 11: push
        repeat (10) send_word(MODE_TICK, 16'h0000);  // poll: release, tap
    endtask

    // Debounce window, push while armed (held time kept), release extremes.
    task automatic test_debounce_window();
        load_config(16'hFFFF, 12'd3, 12'd0, 1'b0);
        repeat (4) send_word(MODE_TICK, 16'hFFFF);
        send_word(MODE_TOUCH, 16'h5555);
        send_word(MODE_TICK, 16'h0000);
        send_word(MODE_TOUCH, 16'hAAAA);     // inside window: no push
        repeat (5) send_word(MODE_TICK, 16'h0001);
        send_word(MODE_TOUCH, 16'h0000);     // push while armed: timer restarts
        repeat (3) send_word(MODE_TICK, 16'hFFFF);
    endtask

    // Zero filter: poll on every tick, held time stays 0, serial tap on
    // the fifth held poll.
    task automatic test_zero_filter();
        load_config(16'h8000, 12'd0, 12'd0, 1'b1);
        send_word(MODE_TICK, 16'h8000);
        send_word(MODE_TOUCH, 16'h0000);
        send_word(MODE_TOUCH, 16'h0000);     // zero distance: no push
        send_word(MODE_TICK, 16'h7FFF);
        repeat (4) send_word(MODE_TICK, 16'h0000);
        send_word(MODE_TICK, 16'h8000);
    endtask

    task automatic test_serial_taps();
        idling_on = 1'b1;
        load_config(16'h8000, 12'd1, 12'd0, 1'b1);
        run_press_traffic(150, 12);
    endtask

    task automatic test_plain_presses();
        idling_on = 1'b0;
        load_config(16'($urandom_range(1, 16'hFFFF)), 12'($urandom_range(2, 6)),
                    12'd0, 1'b0);
        run_press_traffic(150, 8);
    endtask

    // 4 ms polls, 1 s long press: it fires on the 250th held poll and, with
    // serial off, nothing follows it. The pad is left held for the next test.
    task automatic test_long_press_single();
        idling_on = 1'b1;
        load_config(16'h8000, 12'd4, 12'd1, 1'b0);
        repeat (8) send_word(MODE_TICK, free_sample());
        send_word(MODE_TOUCH, 16'($urandom));
        repeat (1040) send_word(MODE_TICK, held_sample());
    endtask

    // Same press with serial on: a repeated long press every fifth poll,
    // then a release with no tap.
    task automatic test_long_press_repeat();
        idling_on = 1'b1;
        load_config(16'h8000, 12'd4, 12'd1, 1'b1);
        repeat (60) send_word(MODE_TICK, held_sample());
        while (poll_on)
            send_word(MODE_TICK, free_sample());
    endtask

    // Upper register extremes; the 4000 ms window swallows every interrupt here.
    task automatic test_slow_extremes();
        idling_on = 1'b1;
        load_config(16'hFFFF, 12'd4000, 12'd4000, 1'b1);
        for (int i = 0; i < 15; i++)
        begin
            repeat ($urandom_range(0, 3)) send_word(MODE_TICK, 16'($urandom));
            send_word(MODE_TOUCH, 16'($urandom));
        end
    endtask

    // Closing stretch at full rate on both sides.
    task automatic test_back_to_back();
        idling_on = 1'b0;
        load_config(16'($urandom_range(1, 16'hFFFF)), 12'd2, 12'd0, 1'b1);
        run_press_traffic(150, 10);
    endtask

    // ------------------------------------------------------------------
    // Output side: ready drops in random stall bursts while idling is on.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            evt_if.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end
        else if (idling_on && $urandom_range(0, 5) == 0)
        begin
            evt_if.ready <= 1'b0;
            stall_left   <= $urandom_range(0, 4);
        end
        else
            evt_if.ready <= 1'b1;
    end

    // Compare each accepted result word with the oldest expectation.
    always @(posedge clk)
    begin : check_results
        tkec_pkg::result_t want;
        if (rst_n && evt_if.valid && evt_if.ready)
        begin
            if (expected_events.size() == 0)
            begin
                $error("event_res: expected none, got %0d", evt_if.event_res);
                err_count++;
            end
            else
            begin
                want = expected_events.pop_front();
                if (evt_if.event_res !== want.event_res)
                begin
                    $error("event_res: expected %0d, got %0d", want.event_res,
                           evt_if.event_res);
                    err_count++;
                end
                if (evt_if.last !== want.last)
                begin
                    $error("last: expected %0d, got %0d", want.last, evt_if.last);
                    err_count++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = tkec_pkg::REG_THRESHOLD;
        cfg_data      = '0;
        pad_if.valid  = 1'b0;
        pad_if.mode   = MODE_TICK;
        pad_if.sample = '0;
        idling_on     = 1'b1;

        // predictor starts from the reset values
        cfg_threshold = '0;
        cfg_filter    = 12'd10;
        cfg_long_sec  = '0;
        cfg_serial    = 1'b0;
        tick_ctr      = '0;
        touch_stamp   = '0;
        poll_left     = '0;
        poll_on       = 1'b0;
        held_time     = '0;
        rep_phase     = '0;
        long_seen     = 1'b0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_debounce_window();
        test_zero_filter();
        test_serial_taps();
        test_plain_presses();
        test_long_press_single();
        test_long_press_repeat();
        test_slow_extremes();
        test_back_to_back();

        drain_events();
        if (err_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/tkec_pkg.sv
hw/rtl/tkec_if.sv
hw/rtl/touch_key_event_classifier.sv
hw/rtl/tkec_checker.sv
verif/touch_key_event_classifier_tb.sv
